// File: design/cs_pkg.sv
// Shared types and constants for the row-wise cosine similarity block.
// No dependencies.
`default_nettype none
package cs_pkg;
  localparam int ELEMENT_BITS_DEF = 16;
  localparam int IN_BITS          = 16;
  localparam int EXT_BITS         = 24;
  localparam int ACC_BITS         = 48;
  localparam int PROD_BITS        = 2 * ACC_BITS;
  localparam int CHUNK_BITS       = 16;
  localparam int CHUNKS           = ACC_BITS / CHUNK_BITS;
  localparam int Q_BITS           = 15;
  localparam int WIDE_BITS        = 126;
  localparam int RHS_SHIFT        = 28;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL_P,
    ST_MUL_R,
    ST_SEARCH,
    ST_DONE
  } cs_state_t;

  typedef struct packed {
    logic capture;
    logic accum;
    logic mul_step;
    logic mul_sel_r;
    logic srch_init;
    logic srch_step;
    logic finish;
  } cs_cmd_t;

  typedef struct packed {
    logic last;
    logic mul_last;
    logic srch_last;
    logic out_free;
  } cs_stat_t;
endpackage
`default_nettype wire

// File: design/cs_ctrl.sv
// Controller state machine for the cosine similarity block.
// Depends on cs_pkg.
`default_nettype none
module cs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cs_pkg::cs_stat_t stat,
  output cs_pkg::cs_cmd_t       cmd
);
  import cs_pkg::*;

  cs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accum     = 1'b1;
        cmd.srch_init = 1'b1;
        state_nxt     = stat.last ? ST_MUL_P : ST_IDLE;
      end
      ST_MUL_P: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        cmd.mul_step  = 1'b1;
        cmd.mul_sel_r = 1'b1;
        if (stat.mul_last) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (stat.srch_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: design/cs_dpath.sv
// Datapath: product registers, 48-bit sums, 48x16 shift-add multiplier
// and the bit-by-bit quotient search. Depends on cs_pkg.
`default_nettype none
module cs_dpath #(
  parameter int ELEMENT_BITS = cs_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [cs_pkg::IN_BITS-1:0]  in_x_value,
  input  wire logic [cs_pkg::IN_BITS-1:0]  in_y_value,
  input  wire logic                        in_row_end,
  input  wire cs_pkg::cs_cmd_t             cmd,
  output cs_pkg::cs_stat_t                 stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cs_pkg::IN_BITS-1:0]       out_cosine
);
  import cs_pkg::*;

  localparam int CNT_BITS = $clog2(CHUNKS);
  localparam int K_BITS   = $clog2(Q_BITS);

  // element sign extension from bit ELEMENT_BITS-1
  logic [EXT_BITS-1:0]     x_w, y_w, x_m, y_m;
  logic signed [EXT_BITS:0] x_s, y_s;
  logic [2*EXT_BITS+1:0]   pxy, pxx, pyy;

  always_comb begin
    x_w = {{(EXT_BITS-IN_BITS){1'b0}}, in_x_value};
    y_w = {{(EXT_BITS-IN_BITS){1'b0}}, in_y_value};
    x_m = x_w & ((EXT_BITS'(1) << ELEMENT_BITS) - EXT_BITS'(1));
    y_m = y_w & ((EXT_BITS'(1) << ELEMENT_BITS) - EXT_BITS'(1));
    x_s = signed'({1'b0, x_m}) - (x_m[ELEMENT_BITS-1] ?
          (signed'((EXT_BITS+1)'(1)) <<< ELEMENT_BITS) : '0);
    y_s = signed'({1'b0, y_m}) - (y_m[ELEMENT_BITS-1] ?
          (signed'((EXT_BITS+1)'(1)) <<< ELEMENT_BITS) : '0);
    pxy = x_s * y_s;
    pxx = x_s * x_s;
    pyy = y_s * y_s;
  end

  logic [ACC_BITS-1:0] pxy_r, pxx_r, pyy_r;
  logic                last_r;
  logic [ACC_BITS-1:0] sxy_r, sxx_r, syy_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pxy_r  <= pxy[ACC_BITS-1:0];
      pxx_r  <= pxx[ACC_BITS-1:0];
      pyy_r  <= pyy[ACC_BITS-1:0];
      last_r <= in_row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      sxy_r <= '0;
      sxx_r <= '0;
      syy_r <= '0;
    end else if (cmd.accum) begin
      sxy_r <= sxy_r + pxy_r;
      sxx_r <= sxx_r + pxx_r;
      syy_r <= syy_r + pyy_r;
    end
  end

  // magnitude of the cross sum; square sums below one LSB clamp to one
  logic                neg;
  logic [ACC_BITS-1:0] mag, xx_c, yy_c;
  always_comb begin
    neg  = sxy_r[ACC_BITS-1];
    mag  = neg ? (~sxy_r + ACC_BITS'(1)) : sxy_r;
    xx_c = (sxx_r[ACC_BITS-1] || sxx_r == '0) ? ACC_BITS'(1) : sxx_r;
    yy_c = (syy_r[ACC_BITS-1] || syy_r == '0) ? ACC_BITS'(1) : syy_r;
  end

  // shared multiplier, one 16-bit chunk of b per cycle, MSB chunk first
  logic [CNT_BITS-1:0]   cnt_r;
  logic [PROD_BITS-1:0]  macc_r, macc_nxt, p_r, r_r;
  logic [ACC_BITS-1:0]   ma, mb;
  logic [CHUNK_BITS-1:0] chunk;
  logic [ACC_BITS+CHUNK_BITS-1:0] pp;
  logic                  mul_last;

  always_comb begin
    ma       = cmd.mul_sel_r ? mag : xx_c;
    mb       = cmd.mul_sel_r ? mag : yy_c;
    chunk    = mb[(CHUNKS-1-32'(cnt_r))*CHUNK_BITS +: CHUNK_BITS];
    pp       = {{CHUNK_BITS{1'b0}}, ma} * {{ACC_BITS{1'b0}}, chunk};
    macc_nxt = {macc_r[PROD_BITS-CHUNK_BITS-1:0], {CHUNK_BITS{1'b0}}}
             + {{(PROD_BITS-ACC_BITS-CHUNK_BITS){1'b0}}, pp};
    mul_last = (cnt_r == CNT_BITS'(CHUNKS-1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      macc_r <= '0;
    end else if (cmd.mul_step) begin
      if (mul_last) begin
        cnt_r  <= '0;
        macc_r <= '0;
      end else begin
        cnt_r  <= cnt_r + CNT_BITS'(1);
        macc_r <= macc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step && mul_last) begin
      if (cmd.mul_sel_r) r_r <= macc_nxt;
      else               p_r <= macc_nxt;
    end
  end

  // greedy search: s = q^2 * P, t = q * P, trial adds bit k to q
  logic [WIDE_BITS-1:0] s_r, t_r, s_try, rhs, p_w;
  logic [Q_BITS-1:0]    q_r;
  logic [K_BITS-1:0]    k_r;
  logic                 pass;
  logic                 srch_last;

  always_comb begin
    p_w   = {{(WIDE_BITS-PROD_BITS){1'b0}}, p_r};
    rhs   = {{(WIDE_BITS-PROD_BITS){1'b0}}, r_r} << RHS_SHIFT;
    s_try = s_r + (t_r << (k_r + K_BITS'(1))) + (p_w << {k_r, 1'b0});
    pass  = (s_try <= rhs);
    srch_last = (k_r == '0) || (pass && k_r == K_BITS'(Q_BITS-1));
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      s_r <= '0;
      t_r <= '0;
      q_r <= '0;
      k_r <= K_BITS'(Q_BITS-1);
    end else if (cmd.srch_step) begin
      if (pass) begin
        s_r <= s_try;
        t_r <= t_r + (p_w << k_r);
        q_r <= q_r | (Q_BITS'(1) << k_r);
      end
      k_r <= k_r - K_BITS'(1);
    end
  end

  logic                out_valid_r;
  logic [IN_BITS-1:0]  out_cosine_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                   out_valid_r <= 1'b0;
    else if (cmd.finish)          out_valid_r <= 1'b1;
    else if (out_ready)           out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish)
      out_cosine_r <= neg ? (~{1'b0, q_r} + IN_BITS'(1)) : {1'b0, q_r};
  end

  always_comb begin
    stat.last      = last_r;
    stat.mul_last  = mul_last;
    stat.srch_last = srch_last;
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_cosine    = out_cosine_r;
endmodule
`default_nettype wire

// File: design/cosine_similarity_rowwise.sv
// Row-wise cosine similarity, top level: controller plus datapath.
// A pair that does not end its row passes through capture and accumulate.
// A row-end pair goes on to its word through capture, accumulate, two
// 48x16 multiplies, 1 search step at saturation or 15 otherwise, load.
// One item is in flight at a time; the output register frees the input side.
// Synchronous active-low reset clears the sums, state and output valid.
`default_nettype none
module cosine_similarity_rowwise #(
  parameter int ELEMENT_BITS = cs_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [cs_pkg::IN_BITS-1:0] in_x_value,
  input  wire logic [cs_pkg::IN_BITS-1:0] in_y_value,
  input  wire logic                       in_row_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [cs_pkg::IN_BITS-1:0]      out_cosine
);
  import cs_pkg::*;

  cs_cmd_t  cmd;
  cs_stat_t stat;

  cs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cs_dpath #(.ELEMENT_BITS(ELEMENT_BITS)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_x_value (in_x_value),
    .in_y_value (in_y_value),
    .in_row_end (in_row_end),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_cosine (out_cosine)
  );
endmodule
`default_nettype wire

// File: design/cs_checker.sv
// Port-level checks for cosine_similarity_rowwise, bound to the top level.
// Depends on cs_pkg.
`default_nettype none
module cs_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [cs_pkg::IN_BITS-1:0] out_cosine
);
  import cs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cosine))
    else $error("output word dropped or changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_cosine) <= 16384 && $signed(out_cosine) >= -16384))
    else $error("cosine out of range");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind cosine_similarity_rowwise cs_checker u_cs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_cosine (out_cosine)
);
`default_nettype wire

// File: dv/cosine_similarity_rowwise_tb.sv
// Self-checking testbench for cosine_similarity_rowwise: rows of element pairs
// in, one signed Q2.14 cosine word out per row. Depends on cs_pkg and the RTL.
`timescale 1ns / 100ps
module cosine_similarity_rowwise_tb;
  import cs_pkg::*;

  typedef struct {
    logic signed [IN_BITS-1:0] x;
    logic signed [IN_BITS-1:0] y;
    logic                      last;
    bit                        drain;  // hold off until every row result is back
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_BITS-1:0] in_x_value = '0;
  logic [IN_BITS-1:0] in_y_value = '0;
  logic in_row_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IN_BITS-1:0] out_cosine;

  pair_t pair_q[$];
  logic [IN_BITS-1:0] cosine_q[$];
  logic [ACC_BITS-1:0] dot_acc = '0, xsq_acc = '0, ysq_acc = '0;
  int errors = 0;
  int rows_seen = 0;
  int pairs_seen = 0;
  int cycle = 0;
  bit in_fire = 1'b0;

  cosine_similarity_rowwise DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit idle_now();
    if (cycle >= 3000 && cycle < 6000) return 1'b0;  // stretch with no idling
    return $urandom_range(99) < 20;
  endfunction

  // clamp a square sum to one LSB when zero or wrapped negative
  function automatic logic [127:0] floor_lsb(logic [ACC_BITS-1:0] v);
    if (v[ACC_BITS-1] || v == '0) return 128'd1;
    return {80'b0, v};
  endfunction

  function automatic logic [IN_BITS-1:0] row_cosine();
    logic [ACC_BITS-1:0] mag;
    logic [127:0] rhs, prod, lhs;
    bit neg;
    int lo, hi, mid;
    neg = dot_acc[ACC_BITS-1];
    mag = neg ? -dot_acc : dot_acc;
    rhs = ({80'b0, mag} * {80'b0, mag}) << RHS_SHIFT;
    prod = floor_lsb(xsq_acc) * floor_lsb(ysq_acc);
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 128'(mid * mid) * prod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return neg ? IN_BITS'(-lo) : IN_BITS'(lo);
  endfunction

  function automatic void accumulate(logic signed [IN_BITS-1:0] x,
                                     logic signed [IN_BITS-1:0] y, logic last);
    dot_acc += ACC_BITS'(48'(signed'(x)) * 48'(signed'(y)));
    xsq_acc += ACC_BITS'(48'(signed'(x)) * 48'(signed'(x)));
    ysq_acc += ACC_BITS'(48'(signed'(y)) * 48'(signed'(y)));
    if (last) begin
      cosine_q.push_back(row_cosine());
      dot_acc = '0;
      xsq_acc = '0;
      ysq_acc = '0;
    end
  endfunction

  task automatic report(string what, logic [IN_BITS-1:0] got, logic [IN_BITS-1:0] want);
    errors++;
    $display("%0t MISMATCH %s: got %0d expected %0d", $time, what,
             signed'(got), signed'(want));
  endtask

  // monitor: handshakes sampled at the rising edge
  always @(posedge clk) begin
    cycle <= cycle + 1;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      pairs_seen++;
      accumulate(in_x_value, in_y_value, in_row_end);
    end
    if (rst_n && out_valid && out_ready) begin
      rows_seen++;
      if (cosine_q.size() == 0) report("word with no row pending", out_cosine, 'x);
      else begin
        if (out_cosine !== cosine_q[0]) report("cosine", out_cosine, cosine_q[0]);
        void'(cosine_q.pop_front());
      end
    end
  end

  // driver: inputs change at the falling edge
  always @(negedge clk) begin
    out_ready <= !idle_now();
    if (rst_n && (!in_valid || in_fire)) begin
      if (pair_q.size() != 0 && !(pair_q[0].drain && cosine_q.size() != 0) &&
          !idle_now()) begin
        in_valid   <= 1'b1;
        in_x_value <= pair_q[0].x;
        in_y_value <= pair_q[0].y;
        in_row_end <= pair_q[0].last;
        void'(pair_q.pop_front());
      end else
        in_valid <= 1'b0;
    end
  end

  task automatic add_pair(int x, int y, bit last, bit drain = 0);
    pair_t p;
    p.x = IN_BITS'(x);
    p.y = IN_BITS'(y);
    p.last = last;
    p.drain = drain;
    pair_q.push_back(p);
  endtask

  function automatic int pick_elem();
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(64) - 32;
      default: return int'(signed'(16'($urandom)));
    endcase
  endfunction

  initial begin
    int len, x, y, mode;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    add_pair(0, 0, 1);                      // all-zero single-pair row
    add_pair(0, 0, 0); add_pair(0, 0, 1);
    add_pair(32767, 32767, 1);              // single pair, cos +1
    add_pair(-32768, 32767, 1);             // extremes, cos -1
    add_pair(-32768, -32768, 0); add_pair(32767, 32767, 1);
    add_pair(4096, 0, 0); add_pair(0, 4096, 1);   // orthogonal
    add_pair(0, 123, 1);                    // one zero vector
    add_pair(1, 1, 0); add_pair(1, -1, 0); add_pair(1, 2, 1);
    add_pair(-1, -1, 1);
    add_pair(12345, -321, 0); add_pair(-32768, 32767, 0); add_pair(7, 9, 1);
    add_pair(32767, -32768, 0, 1); add_pair(-32768, 32767, 1);

    // long row of extreme elements: large sums, cosine of full magnitude
    for (int i = 0; i < 64; i++) add_pair(-32768, 32767, i == 63, i == 0);

    // random rows, mostly short, with correlated content
    for (int n = 0; n < 1000; n += len) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      mode = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        x = pick_elem();
        case (mode)
          0: y = x;
          1: y = (x == -32768) ? 32767 : -x;
          2: y = x / 2 + int'($urandom_range(16)) - 8;
          default: y = pick_elem();
        endcase
        add_pair(x, y, i == len - 1, n > 400 && n < 420 && i == 0);
      end
    end

    wait (pair_q.size() == 0 && !in_valid && cosine_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d element pairs in %0d rows: zero, single-pair, +/-1,", pairs_seen,
             rows_seen);
    $display("long extreme rows and random correlated rows under random stalls");
    if (errors == 0 && cosine_q.size() == 0)
      $display("cosine_similarity_rowwise_tb: clean");
    else
      $display("cosine_similarity_rowwise_tb: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d rows pending", cosine_q.size());
    $display("cosine_similarity_rowwise_tb: errors");
    $finish;
  end
endmodule
